>>> hdl/mvc_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the minimum vertex cover search block.
package mvc_pkg;

    localparam int STORE_ROWS    = 16;
    localparam int ROW_W         = 16;
    localparam int ROW_IDX_W     = 4;
    localparam int NV_W          = 5;
    localparam int SIZE_W        = 5;
    localparam int MASK_W        = 16;
    localparam int MAX_N_DEFAULT = 16;

    localparam logic [NV_W-1:0] NV_RESET = 5'd16;

    typedef struct packed {
        logic                 en;
        logic [ROW_IDX_W-1:0] addr;
        logic [ROW_W-1:0]     bits;
    } store_wr_t;

endpackage

>>> hdl/mvc_cover_check.sv
`timescale 1ns / 1ps
// Adjacency bit store and the shared per-vertex edge cover test.
module mvc_cover_check #(
    parameter int MAX_N = mvc_pkg::MAX_N_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mvc_pkg::store_wr_t           wr,
    input  logic [MAX_N-1:0]             cand,
    input  logic [MAX_N-1:0]             vmask,
    input  logic [$clog2(MAX_N+1)-1:0]   vidx,
    output logic                         fail
);

    localparam int CW = $clog2(MAX_N + 1);
    localparam int IW = $clog2(MAX_N);

    logic [mvc_pkg::ROW_W-1:0] adj_reg [mvc_pkg::STORE_ROWS];

    logic [31:0]                       ipad;
    logic [mvc_pkg::ROW_IDX_W-1:0]     sel;
    logic                              in_store;
    logic [mvc_pkg::ROW_W-1:0]         row;
    logic [mvc_pkg::STORE_ROWS-1:0]    col16;
    logic [31:0]                       rpad;
    logic [31:0]                       cpad;
    logic [MAX_N-1:0]                  above;
    logic [MAX_N-1:0]                  upper;
    logic [MAX_N-1:0]                  back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < mvc_pkg::STORE_ROWS; r++)
            begin
                adj_reg[r] <= '0;
            end
        end
        else if (wr.en)
        begin
            adj_reg[wr.addr] <= wr.bits;
        end
    end

    always_comb
    begin
        ipad     = 32'(vidx);
        sel      = ipad[mvc_pkg::ROW_IDX_W-1:0];
        in_store = (ipad < 32'(mvc_pkg::STORE_ROWS));
        row      = adj_reg[sel];
        for (int j = 0; j < mvc_pkg::STORE_ROWS; j++)
        begin
            col16[j] = adj_reg[j][sel];
        end
        rpad  = 32'(row);
        cpad  = 32'(col16);
        above = {MAX_N{1'b1}} << ({1'b0, vidx} + {{CW{1'b0}}, 1'b1});
        upper = rpad[MAX_N-1:0] & vmask & above & {MAX_N{in_store}};
        back  = cpad[MAX_N-1:0] & vmask & above;
        fail  = !cand[ipad[IW-1:0]] && (|(upper & ~(cand & back)));
    end

endmodule

>>> hdl/min_vertex_cover_search.sv
`timescale 1ns / 1ps
// Minimum vertex cover search: row loading, subset sequencer and result register.
// A row item without the last mark only writes its row into the store; busy stays low.
// A last row starts the search: each subset is checked vertex by vertex from vertex 0 up
// until one fails or all n pass, and each successor scan goes bit by bit from bit n - 1
// down to the bit moved. At most 2^n - 1 subsets are checked. busy is low in the done
// cycle, so the next item may go with it. Results cannot be stalled. Reset clears the
// row store and sets num_vertices to 16.
module min_vertex_cover_search #(
    parameter int MAX_N = mvc_pkg::MAX_N_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mvc_pkg::ROW_IDX_W-1:0] row_index,
    input  logic [mvc_pkg::ROW_W-1:0]     row_bits,
    input  logic                          last_row,
    output logic                          done,
    output logic [mvc_pkg::MASK_W-1:0]    cover_mask,
    output logic [mvc_pkg::SIZE_W-1:0]    cover_size,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mvc_pkg::NV_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_N + 1);
    localparam int IW = $clog2(MAX_N);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_NEXT
    } state_t;

    state_t                     state_reg, state_next;
    logic [mvc_pkg::NV_W-1:0]   nv_reg, nv_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              i_reg, i_next;
    logic [CW-1:0]              m_reg, m_next;
    logic [IW-1:0]              b_reg, b_next;
    logic                       run_reg, run_next;
    logic [MAX_N-1:0]           cand_reg, cand_next;
    logic [MAX_N-1:0]           vmask_reg, vmask_next;
    logic                       done_reg, done_next;
    logic [mvc_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [mvc_pkg::SIZE_W-1:0] size_reg, size_next;

    mvc_pkg::store_wr_t         wr;
    logic                       accept;
    logic                       fail;
    logic [CW-1:0]              n_calc;
    logic [MAX_N-1:0]           bit_sel;
    logic                       found;
    logic [31:0]                cand_pad;

    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign cover_mask = mask_reg;
    assign cover_size = size_reg;
    assign accept     = start && !busy;

    assign wr.en   = accept;
    assign wr.addr = row_index;
    assign wr.bits = row_bits;

    mvc_cover_check #(
        .MAX_N (MAX_N)
    ) u_check (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .cand  (cand_reg),
        .vmask (vmask_reg),
        .vidx  (i_reg),
        .fail  (fail)
    );

    always_comb
    begin
        if (nv_reg == '0)
        begin
            n_calc = CW'(1);
        end
        else if (32'(nv_reg) > 32'(MAX_N))
        begin
            n_calc = CW'(MAX_N);
        end
        else
        begin
            n_calc = CW'(nv_reg);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        nv_next    = nv_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        m_next     = m_reg;
        b_next     = b_reg;
        run_next   = run_reg;
        cand_next  = cand_reg;
        vmask_next = vmask_reg;
        done_next  = 1'b0;
        mask_next  = mask_reg;
        size_next  = size_reg;
        bit_sel    = {{(MAX_N-1){1'b0}}, 1'b1} << b_reg;
        found      = 1'b0;
        cand_pad   = 32'(cand_reg);

        if (cfg_valid && cfg_ready)
        begin
            nv_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && last_row)
                begin
                    n_next     = n_calc;
                    vmask_next = ~({MAX_N{1'b1}} << n_calc);
                    k_next     = CW'(1);
                    cand_next  = {{(MAX_N-1){1'b0}}, 1'b1};
                    i_next     = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (i_reg == n_reg)
                begin
                    done_next  = 1'b1;
                    mask_next  = cand_pad[mvc_pkg::MASK_W-1:0];
                    size_next  = mvc_pkg::SIZE_W'(k_reg);
                    state_next = ST_IDLE;
                end
                else if (fail)
                begin
                    b_next     = IW'(n_reg - {{(CW-1){1'b0}}, 1'b1});
                    run_next   = 1'b1;
                    m_next     = '0;
                    state_next = ST_NEXT;
                end
                else
                begin
                    i_next = i_reg + {{(CW-1){1'b0}}, 1'b1};
                end
            end
            ST_NEXT:
            begin
                // strip the packed run at the top, then bump the next element up
                if (run_reg && cand_reg[b_reg])
                begin
                    cand_next = cand_reg & ~bit_sel;
                    m_next    = m_reg + {{(CW-1){1'b0}}, 1'b1};
                end
                else if (cand_reg[b_reg])
                begin
                    found      = 1'b1;
                    cand_next  = (cand_reg & ~bit_sel)
                               | (~({MAX_N{1'b1}} << ({1'b0, m_reg} + 1'b1))
                                  << ({1'b0, b_reg} + 1'b1));
                    i_next     = '0;
                    state_next = ST_CHECK;
                end
                else
                begin
                    run_next = 1'b0;
                end

                if (!found)
                begin
                    if (b_reg == '0)
                    begin
                        k_next     = k_reg + {{(CW-1){1'b0}}, 1'b1};
                        cand_next  = ~({MAX_N{1'b1}} << ({1'b0, k_reg} + 1'b1));
                        i_next     = '0;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        b_next = b_reg - {{(IW-1){1'b0}}, 1'b1};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            nv_reg    <= mvc_pkg::NV_RESET;
            n_reg     <= CW'(1);
            k_reg     <= CW'(1);
            i_reg     <= '0;
            m_reg     <= '0;
            b_reg     <= '0;
            run_reg   <= 1'b0;
            cand_reg  <= '0;
            vmask_reg <= '0;
            done_reg  <= 1'b0;
            mask_reg  <= '0;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nv_reg    <= nv_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            m_reg     <= m_next;
            b_reg     <= b_next;
            run_reg   <= run_next;
            cand_reg  <= cand_next;
            vmask_reg <= vmask_next;
            done_reg  <= done_next;
            mask_reg  <= mask_next;
            size_reg  <= size_next;
        end
    end

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cover_size != '0))
        else $error("reported cover has size zero");

    a_size_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((MAX_N > mvc_pkg::MASK_W) || ($countones(cover_mask) == cover_size)))
        else $error("cover mask population differs from cover size");

    a_search_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_row) |=> busy)
        else $error("last row did not start the search");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    a_size_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> ((k_reg <= n_reg) && (k_reg != '0)))
        else $error("subset size left the vertex range");

endmodule

>>> sim/cover_checker.sv
`timescale 1ns / 1ps
// Cover checker: watches the row, result and vertex-count channels, predicts and compares.
module cover_checker #(
    parameter int MAX_N = mvc_pkg::MAX_N_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [mvc_pkg::ROW_IDX_W-1:0] row_index,
    input  logic [mvc_pkg::ROW_W-1:0]     row_bits,
    input  logic                          last_row,
    input  logic                          done,
    input  logic [mvc_pkg::MASK_W-1:0]    cover_mask,
    input  logic [mvc_pkg::SIZE_W-1:0]    cover_size,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mvc_pkg::NV_W-1:0]      cfg_data,
    output int                            errors,
    output int                            pending,
    output int                            covers_checked
);

    typedef struct packed {
        logic [mvc_pkg::MASK_W-1:0] mask;
        logic [mvc_pkg::SIZE_W-1:0] size;
    } cover_t;

    logic [mvc_pkg::ROW_W-1:0] adj_rows [mvc_pkg::STORE_ROWS];
    logic [mvc_pkg::NV_W-1:0]  vertex_count;
    cover_t                    expected_covers [$];

    function automatic logic [31:0] row_word(input int v);
        if (v < mvc_pkg::STORE_ROWS)
        begin
            return {16'h0000, adj_rows[v]};
        end
        return 32'h0;
    endfunction

    function automatic void solve_cover(output logic [mvc_pkg::MASK_W-1:0] mask_o,
                                        output logic [mvc_pkg::SIZE_W-1:0] size_o);
        int          n;
        int          i;
        int          j;
        int          k;
        int          t;
        logic [31:0] vmask;
        logic [31:0] subset;
        logic [31:0] row_j;
        logic [31:0] fwd_edges [MAX_N];
        logic [31:0] rev_cover [MAX_N];
        int          pick [MAX_N];
        bit          ok;
        bit          found;
        bit          more;
        n = vertex_count;
        if (n < 1)
            n = 1;
        if (n > MAX_N)
            n = MAX_N;
        vmask = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 32'd1);
        for (i = 0; i < n; i++)
        begin
            fwd_edges[i] = row_word(i) & vmask & ~((32'd2 << i) - 32'd1);
            rev_cover[i] = 32'h0;
        end
        for (j = 0; j < n; j++)
        begin
            row_j = row_word(j);
            for (i = 0; i < j; i++)
            begin
                if (row_j[i])
                    rev_cover[i] |= 32'd1 << j;
            end
        end
        found  = 1'b0;
        mask_o = vmask[mvc_pkg::MASK_W-1:0];
        size_o = mvc_pkg::SIZE_W'(n);
        for (k = 1; k <= n && !found; k++)
        begin
            for (t = 0; t < k; t++)
                pick[t] = t;
            more = 1'b1;
            while (more && !found)
            begin
                subset = 32'h0;
                for (t = 0; t < k; t++)
                    subset |= 32'd1 << pick[t];
                ok = 1'b1;
                for (i = 0; i < n; i++)
                begin
                    if (!subset[i] && (fwd_edges[i] & ~(subset & rev_cover[i])) != 32'h0)
                        ok = 1'b0;
                end
                if (ok)
                begin
                    found  = 1'b1;
                    mask_o = subset[mvc_pkg::MASK_W-1:0];
                    size_o = mvc_pkg::SIZE_W'(k);
                end
                else
                begin
                    t = k;
                    while (t > 0 && pick[t-1] >= n - k + t - 1)
                        t--;
                    if (t == 0)
                        more = 1'b0;
                    else
                    begin
                        pick[t-1]++;
                        for (j = t; j < k; j++)
                            pick[j] = pick[j-1] + 1;
                    end
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cover_t want;
        if (!rst_n)
        begin
            vertex_count = mvc_pkg::NV_RESET;
            for (int r = 0; r < mvc_pkg::STORE_ROWS; r++)
                adj_rows[r] = '0;
            expected_covers.delete();
            errors         = 0;
            covers_checked = 0;
            pending       <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_covers.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected cover: expected none, actual mask %h size %0d",
                             $time, cover_mask, cover_size);
                end
                else
                begin
                    want = expected_covers.pop_front();
                    covers_checked++;
                    if (cover_mask !== want.mask)
                    begin
                        errors++;
                        $display("%0t: cover_mask mismatch: expected %h actual %h",
                                 $time, want.mask, cover_mask);
                    end
                    if (cover_size !== want.size)
                    begin
                        errors++;
                        $display("%0t: cover_size mismatch: expected %0d actual %0d",
                                 $time, want.size, cover_size);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                vertex_count = cfg_data;
            if (start && !busy)
            begin
                adj_rows[row_index] = row_bits;
                if (last_row)
                begin
                    solve_cover(want.mask, want.size);
                    expected_covers.push_back(want);
                end
            end
            pending <= expected_covers.size();
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives graph rows and vertex-count writes into the cover search and reports the verdict.
module tb_top;
    import mvc_pkg::*;

    localparam int MAX_N       = MAX_N_DEFAULT;
    localparam int ITEM_TARGET = 1500;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [ROW_IDX_W-1:0] row_index;
    logic [ROW_W-1:0]     row_bits;
    logic                 last_row;
    logic                 done;
    logic [MASK_W-1:0]    cover_mask;
    logic [SIZE_W-1:0]    cover_size;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [NV_W-1:0]      cfg_data;

    int errors;
    int pending;
    int covers_checked;
    int items_sent = 0;
    int nv_writes  = 0;
    int active_n   = MAX_N;
    bit no_gaps    = 1'b0;

    always #5 clk = ~clk;

    min_vertex_cover_search #(
        .MAX_N(MAX_N)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .row_index (row_index),
        .row_bits  (row_bits),
        .last_row  (last_row),
        .done      (done),
        .cover_mask(cover_mask),
        .cover_size(cover_size),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cover_checker #(
        .MAX_N(MAX_N)
    ) u_cover_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .row_index     (row_index),
        .row_bits      (row_bits),
        .last_row      (last_row),
        .done          (done),
        .cover_mask    (cover_mask),
        .cover_size    (cover_size),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .covers_checked(covers_checked)
    );

    task automatic hold_off();
        int gap;
        if (!no_gaps)
        begin
            gap = $urandom_range(0, 7);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_row(input logic [ROW_IDX_W-1:0] idx, input logic [ROW_W-1:0] val,
                            input logic is_last);
        hold_off();
        start     <= 1'b1;
        row_index <= idx;
        row_bits  <= val;
        last_row  <= is_last;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_nv(input logic [NV_W-1:0] v);
        int gap;
        drain();
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        repeat (gap) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        nv_writes++;
        active_n = (v == 0) ? 1 : ((v > MAX_N) ? MAX_N : int'(v));
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        case ($urandom_range(0, 3))
            0: return ROW_W'($urandom & $urandom);
            1: return ROW_W'($urandom);
            2: return ROW_W'($urandom | $urandom);
            default: return ROW_W'($urandom & $urandom & $urandom);
        endcase
    endfunction

    task automatic load_graph();
        int               order [STORE_ROWS + 4];
        int               cnt;
        int               kind;
        int               extra;
        int               i;
        int               j;
        int               tmp;
        logic [31:0]      hubs;
        logic [31:0]      below;
        logic [ROW_W-1:0] val;
        bit               broken;
        broken = 1'b0;
        hubs   = 32'h0;
        if (active_n > 8)
        begin
            // keep the cover within at most three hub vertices so the search stays short
            for (i = $urandom_range(1, 3); i > 0; i--)
                hubs[$urandom_range(0, active_n - 1)] = 1'b1;
            cnt = STORE_ROWS;
            for (i = 0; i < cnt; i++)
                order[i] = i;
        end
        else
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                extra = $urandom_range(0, (STORE_ROWS - active_n < 3) ? STORE_ROWS - active_n : 3);
                cnt = active_n + extra;
                for (i = 0; i < active_n; i++)
                    order[i] = i;
                for (i = active_n; i < cnt; i++)
                    order[i] = $urandom_range(active_n, STORE_ROWS - 1);
            end
            else
            begin
                broken = (kind == 9);
                cnt = $urandom_range(1, broken ? 4 : 3);
                for (i = 0; i < cnt; i++)
                    order[i] = $urandom_range(0, STORE_ROWS - 1);
            end
        end
        for (i = cnt - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < cnt; i++)
        begin
            val = random_row();
            if (hubs != 0)
            begin
                below = (32'd2 << order[i]) - 32'd1;
                val = hubs[order[i]] ? {ROW_W{1'b1}} : (val & ROW_W'(hubs | below));
            end
            send_row(ROW_IDX_W'(order[i]), val, (i == cnt - 1) && !broken);
        end
    endtask

    initial
    begin
        int graphs;
        rst_n     = 1'b0;
        start     = 1'b0;
        row_index = '0;
        row_bits  = '0;
        last_row  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full vertex count from reset: self-loop, back bits only, single-vertex covers
        send_row(4'd0,  16'h0001, 1'b1);
        send_row(4'd15, 16'hFFFF, 1'b1);
        send_row(4'd0,  16'h8000, 1'b1);
        send_row(4'd3,  16'h8000, 1'b1);
        send_row(4'd3,  16'h0000, 1'b0);
        send_row(4'd0,  16'h0000, 1'b0);
        send_row(4'd15, 16'h0000, 1'b1);
        write_nv(5'd0);
        send_row(4'd0,  16'hFFFF, 1'b1);
        send_row(4'd9,  16'h5A5A, 1'b1);
        write_nv(5'd31);
        send_row(4'd7,  16'h0000, 1'b1);
        write_nv(5'd2);
        send_row(4'd0,  16'h0002, 1'b0);
        send_row(4'd1,  16'h0000, 1'b1);
        send_row(4'd0,  16'h0000, 1'b0);
        send_row(4'd1,  16'h0001, 1'b1);
        write_nv(5'd3);
        send_row(4'd0,  16'h0000, 1'b0);
        send_row(4'd1,  16'h0004, 1'b0);
        send_row(4'd2,  16'h0002, 1'b1);
        send_row(4'd2,  16'hFFF8, 1'b1);
        write_nv(5'd16);
        for (int r = 0; r < STORE_ROWS; r++)
            send_row(ROW_IDX_W'(r), 16'h0000, r == STORE_ROWS - 1);

        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: write_nv(NV_W'($urandom_range(16, 31)));
                1: write_nv(NV_W'($urandom_range(9, 15)));
                2: write_nv(5'd0);
                default: write_nv(NV_W'($urandom_range(1, 8)));
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            for (graphs = $urandom_range(3, 10); graphs > 0; graphs--)
            begin
                load_graph();
                if ($urandom_range(0, 7) == 0)
                    drain();
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        $display("Run covered %0d row items and %0d vertex-count writes, counts 0 to 31.",
                 items_sent, nv_writes);
        $display("Covers compared: %0d, mismatches: %0d.", covers_checked, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
